>>> rtl/core/sfc_pkg.sv
// Package with shared types, codes and helper functions of the stuffed frame CRC-16 checker.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned KIND_W  = 2;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h61;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h62;
	localparam logic [CRC_W-1:0]  POLY_RESET   = 16'h6113;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;

	// Parser modes.
	typedef enum logic [2:0] {
		MODE_AWAIT_OPEN  = 3'd0,
		MODE_IN_FRAME    = 3'd1,
		MODE_AFTER_CLOSE = 3'd2,
		MODE_HUNT        = 3'd3,
		MODE_HUNT_SKIP   = 3'd4,
		MODE_HUNT_FLAG   = 3'd5
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  data_byte;
		logic               crc_ok;
		logic [COUNT_W-1:0] data_count;
		logic [COUNT_W-1:0] escape_count;
	} out_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_value;
		logic [BYTE_W-1:0] escape_value;
		logic [CRC_W-1:0]  crc_poly_low;
	} cfg_regs_t;

	// Saturating increment of a frame count.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

	// Bit permutation: old bits 7,3,6,2,5,1,4,0 go to positions 7..0.
	function automatic logic [BYTE_W-1:0] permute_byte(input logic [BYTE_W-1:0] b);
		permute_byte = {b[7], b[3], b[6], b[2], b[5], b[1], b[4], b[0]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfc_crc_byte.sv
// One-byte MSB-first CRC-16 update with a programmable generator.
`timescale 1ns / 1ps
`default_nettype none

module sfc_crc_byte
	import sfc_pkg::*;
(
	input  wire logic [CRC_W-1:0]  crc,
	input  wire logic [BYTE_W-1:0] data,
	input  wire logic [CRC_W-1:0]  poly,
	output logic [CRC_W-1:0]       crc_next
);

	// Eight shift steps of the long division, unrolled into XOR logic.
	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

`default_nettype wire

>>> rtl/core/sfc_parser.sv
// Frame parser: deframing state machine, delay line, counts and CRC register.
`timescale 1ns / 1ps
`default_nettype none

module sfc_parser
	import sfc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire cfg_regs_t cfg,
	output logic           res_valid,
	output out_item_t      res
);

	mode_t              mode_q, mode_d;
	logic               esc_q, esc_d;
	logic [BYTE_W-1:0]  held0_q, held0_d, held1_q, held1_d;
	logic [1:0]         held_cnt_q, held_cnt_d;
	logic [CRC_W-1:0]   crc_q, crc_d, crc_fed;
	logic [COUNT_W-1:0] dcnt_q, dcnt_d, ecnt_q, ecnt_d;
	logic [CRC_W-1:0]   sum;
	logic               is_flag, is_esc;

	// CRC update for the byte that leaves the delay line.
	sfc_crc_byte u_crc (
		.crc      (crc_q),
		.data     (permute_byte(held0_q)),
		.poly     (cfg.crc_poly_low),
		.crc_next (crc_fed)
	);

	assign is_flag = (item.rx_byte == cfg.flag_value);
	assign is_esc  = (item.rx_byte == cfg.escape_value);

	// Received checksum; missing bytes of a short frame read as zero.
	always_comb begin
		case (held_cnt_q)
			2'd2:    sum = {held0_q, held1_q};
			2'd1:    sum = {{(CRC_W-BYTE_W){1'b0}}, held0_q};
			default: sum = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_AWAIT_OPEN;
			esc_q      <= 1'b0;
			held0_q    <= '0;
			held1_q    <= '0;
			held_cnt_q <= '0;
			crc_q      <= '0;
			dcnt_q     <= '0;
			ecnt_q     <= '0;
		end else if (step) begin
			mode_q     <= mode_d;
			esc_q      <= esc_d;
			held0_q    <= held0_d;
			held1_q    <= held1_d;
			held_cnt_q <= held_cnt_d;
			crc_q      <= crc_d;
			dcnt_q     <= dcnt_d;
			ecnt_q     <= ecnt_d;
		end
	end

	// Next state and result for the item in the input register.
	always_comb begin
		mode_d     = mode_q;
		esc_d      = esc_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		held_cnt_d = held_cnt_q;
		crc_d      = crc_q;
		dcnt_d     = dcnt_q;
		ecnt_d     = ecnt_q;
		res_valid  = 1'b0;
		res        = '0;

		if (item.end_of_stream) begin
			mode_d     = MODE_AWAIT_OPEN;
			esc_d      = 1'b0;
			held0_d    = '0;
			held1_d    = '0;
			held_cnt_d = '0;
			crc_d      = '0;
			dcnt_d     = '0;
			ecnt_d     = '0;
		end else begin
			unique case (mode_q)
				MODE_AWAIT_OPEN: begin
					esc_d      = 1'b0;
					held0_d    = '0;
					held1_d    = '0;
					held_cnt_d = '0;
					crc_d      = '0;
					dcnt_d     = '0;
					ecnt_d     = '0;
					mode_d     = MODE_IN_FRAME;
				end
				MODE_IN_FRAME: begin
					if (!esc_q && is_esc) begin
						esc_d  = 1'b1;
						ecnt_d = sat_inc(ecnt_q);
					end else if (!esc_q && is_flag) begin
						res_valid        = 1'b1;
						res.kind         = KIND_VERDICT;
						res.crc_ok       = (crc_q == sum);
						res.data_count   = dcnt_q;
						res.escape_count = ecnt_q;
						mode_d           = MODE_AFTER_CLOSE;
					end else begin
						esc_d = 1'b0;
						if (held_cnt_q == 2'd0) begin
							held0_d    = item.rx_byte;
							held_cnt_d = 2'd1;
						end else if (held_cnt_q == 2'd1) begin
							held1_d    = item.rx_byte;
							held_cnt_d = 2'd2;
						end else begin
							held0_d       = held1_q;
							held1_d       = item.rx_byte;
							crc_d         = crc_fed;
							dcnt_d        = sat_inc(dcnt_q);
							res_valid     = 1'b1;
							res.kind      = KIND_DATA;
							res.data_byte = held0_q;
						end
					end
				end
				MODE_AFTER_CLOSE: begin
					if (is_flag) begin
						esc_d      = 1'b0;
						held0_d    = '0;
						held1_d    = '0;
						held_cnt_d = '0;
						crc_d      = '0;
						dcnt_d     = '0;
						ecnt_d     = '0;
						mode_d     = MODE_IN_FRAME;
					end else begin
						res_valid        = 1'b1;
						res.kind         = KIND_DISCARD;
						res.data_count   = dcnt_q;
						res.escape_count = ecnt_q;
						mode_d           = MODE_HUNT;
					end
				end
				MODE_HUNT: begin
					if (is_esc) begin
						mode_d = MODE_HUNT_SKIP;
					end else if (is_flag) begin
						mode_d = MODE_HUNT_FLAG;
					end
				end
				MODE_HUNT_SKIP: begin
					mode_d = MODE_HUNT;
				end
				MODE_HUNT_FLAG: begin
					if (is_flag) begin
						esc_d      = 1'b0;
						held0_d    = '0;
						held1_d    = '0;
						held_cnt_d = '0;
						crc_d      = '0;
						dcnt_d     = '0;
						ecnt_d     = '0;
						mode_d     = MODE_IN_FRAME;
					end else begin
						mode_d = MODE_HUNT;
					end
				end
				default: begin
					mode_d     = MODE_AWAIT_OPEN;
					esc_d      = 1'b0;
					held0_d    = '0;
					held1_d    = '0;
					held_cnt_d = '0;
					crc_d      = '0;
					dcnt_d     = '0;
					ecnt_d     = '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sfc_out_reg.sv
// Result register that holds one beat until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module sfc_out_reg
	import sfc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire out_item_t load_data,
	output logic           can_load,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	logic      valid_q;
	out_item_t data_q;

	// Free when empty or when the held beat leaves in this cycle.
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/stuffed_frame_crc16_checker_top.sv
// A beat passes from the input register through the parser into the result register.
// One beat per cycle is taken while in_stall is low, via combinational parser and CRC.
// The input register and the result register each hold one beat; stall of the output
// side reaches the input side only while both are full.
// Reset (arst_n low, asynchronous): registers return to 0x61, 0x62 and 0x6113, the parser
// takes its first byte as the opening flag, and no beat is held on either side.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_crc16_checker_top
	import sfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t cfg_q;
	in_item_t  in_s1;
	logic      valid_s1;
	logic      step;
	logic      can_load;
	logic      res_valid;
	out_item_t res;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value   <= FLAG_RESET;
			cfg_q.escape_value <= ESCAPE_RESET;
			cfg_q.crc_poly_low <= POLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FLAG:   cfg_q.flag_value   <= cfg_data[BYTE_W-1:0];
				CFG_ESCAPE: cfg_q.escape_value <= cfg_data[BYTE_W-1:0];
				CFG_POLY:   cfg_q.crc_poly_low <= cfg_data[CRC_W-1:0];
				default:    ;
			endcase
		end
	end

	// The input beat is processed once the result register can take its outcome.
	assign step     = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_data;
		end
	end

	sfc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (in_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	sfc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
